FILE: rtl/chip8_pkg.sv
// Shared types, codes and tables of the CHIP-8 interpreter core.
package chip8_pkg;

    localparam int LO_WIDTH    = 64;
    localparam int LO_HEIGHT   = 32;
    localparam int DISP_PIXELS = 4 * LO_WIDTH * LO_HEIGHT;
    localparam int DISP_AW     = $clog2(DISP_PIXELS);
    localparam int FONT_BYTES  = 80;

    typedef enum logic [2:0] {
        OP_WRITE_MEM   = 3'd0,
        OP_STEP        = 3'd1,
        OP_TICK        = 3'd2,
        OP_KEY_PRESS   = 3'd3,
        OP_CLEAR_KEYS  = 3'd4,
        OP_READ_PIXEL  = 3'd5,
        OP_READ_MEM    = 3'd6,
        OP_REINIT      = 3'd7
    } op_code_t;

    localparam logic [2:0] FLT_NONE      = 3'd0;
    localparam logic [2:0] FLT_OVERFLOW  = 3'd1;
    localparam logic [2:0] FLT_UNDERFLOW = 3'd2;
    localparam logic [2:0] FLT_EXIT      = 3'd3;
    localparam logic [2:0] FLT_UNKNOWN   = 3'd4;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDPIX,
        ST_RDMEM,
        ST_FETCH1,
        ST_FETCH2,
        ST_RDX,
        ST_RDY,
        ST_EXEC,
        ST_WB,
        ST_WALK,
        ST_SPR_ROW,
        ST_SPR_HI,
        ST_SPR_LO,
        ST_SPR_COL,
        ST_SPR_PIX,
        ST_SPR_END,
        ST_BCD,
        ST_BLK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        WK_CLEAR,
        WK_DOWN,
        WK_RIGHT,
        WK_LEFT
    } walk_kind_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0,
        8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

FILE: rtl/chip8_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/chip8_cpu_core_top.sv
// CHIP-8 / SCHIP interpreter core: a sequencer around RAM, display, register and stack memories.
// After reset, and after a reinit beat, a clearing pass over max(MEM_BYTES, 8192) addresses loads
// the font and clears RAM, display and V registers; no beat is accepted during it.
// A step passes through FETCH1, FETCH2, RDX and RDY to EXEC before its result in FINISH.
// Sprites go row by row and read and rewrite only drawn pixels; scrolls and clears walk every
// display pixel, so their length is set by the single display memory port.
// One beat is worked on at a time; the result register lets the next beat in while it waits.
module chip8_cpu_core_top
    import chip8_pkg::*;
#(
    parameter int MEM_BYTES     = 4096,
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], address[15:3], data_byte[23:16], key_index[27:24], random_byte[35:28]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], program_counter[23:8], display_changed[24], sound_on[25],
    // hires_mode[26], halted[27], waiting_for_key[28], fault[31:29]
    output logic [31:0] m_tdata
);

    localparam int AW      = $clog2(MEM_BYTES);
    localparam int SW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW      = $clog2(STACK_DEPTH + 1);
    localparam int CLR_LEN = (MEM_BYTES > DISP_PIXELS) ? MEM_BYTES : DISP_PIXELS;
    localparam int CW      = $clog2(CLR_LEN);

    function automatic logic [AW-1:0] mem_wrap(input logic [16:0] a);
        logic [24:0] t;
        t = {8'b0, a};
        for (int k = 7; k >= 0; k--)
        begin
            if (t >= (25'(MEM_BYTES) << k))
            begin
                t = t - (25'(MEM_BYTES) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    state_t          state_reg, state_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            clr_out_reg, clr_out_next;
    logic [15:0]     opc_reg, opc_next;
    logic [7:0]      vx_reg, vx_next;
    logic [7:0]      vy_reg, vy_next;
    logic [7:0]      flag_reg, flag_next;
    logic [7:0]      hi_reg, hi_next;
    logic [15:0]     pc_reg, pc_next;
    logic [15:0]     i_reg, i_next;
    logic [LW-1:0]   sp_reg, sp_next;
    logic [7:0]      dt_reg, dt_next;
    logic [7:0]      st_reg, st_next;
    logic [15:0]     keys_reg, keys_next;
    logic [7:0][7:0] flags_reg, flags_next;
    logic            hires_reg, hires_next;
    logic            halt_reg, halt_next;
    logic [7:0]      rd_reg, rd_next;
    logic            chg_reg, chg_next;
    logic            wait_reg, wait_next;
    logic [2:0]      flt_reg, flt_next;
    walk_kind_t      wk_kind_reg, wk_kind_next;
    logic            wk_desc_reg, wk_desc_next;
    logic [13:0]     wk_cnt_reg, wk_cnt_next;
    logic [13:0]     wk_total_reg, wk_total_next;
    logic            wk_phase_reg, wk_phase_next;
    logic [12:0]     wk_dst_reg, wk_dst_next;
    logic [4:0]      r_reg, r_next;
    logic [4:0]      c_reg, c_next;
    logic [15:0]     bits_reg, bits_next;
    logic            coll_reg, coll_next;
    logic [6:0]      xp_reg, xp_next;
    logic [6:0]      yp_reg, yp_next;
    logic [3:0]      k_reg, k_next;
    logic            blk_phase_reg, blk_phase_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_data_reg, out_data_next;

    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [7:0]      mem_wd, mem_rd;
    logic            dsp_we;
    logic [12:0]     dsp_wa, dsp_ra;
    logic [0:0]      dsp_wd, dsp_rd;
    logic            v_we;
    logic [3:0]      v_wa, v_ra;
    logic [7:0]      v_wd, v_rd;
    logic            stk_we;
    logic [SW-1:0]   stk_wa, stk_ra;
    logic [15:0]     stk_wd, stk_rd;

    chip8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd)
    );
    chip8_ram #(.WIDTH(1), .DEPTH(DISP_PIXELS)) u_disp (
        .clk(clk), .we(dsp_we), .waddr(dsp_wa), .wdata(dsp_wd), .raddr(dsp_ra), .rdata(dsp_rd)
    );
    chip8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );
    chip8_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
    );

    // Input beat fields.
    op_code_t    in_op;
    logic [12:0] in_addr;
    logic [7:0]  in_data;
    logic [3:0]  in_key;
    logic [7:0]  in_rnd;

    assign in_op   = op_code_t'(s_tdata[2:0]);
    assign in_addr = s_tdata[15:3];
    assign in_data = s_tdata[23:16];
    assign in_key  = s_tdata[27:24];
    assign in_rnd  = s_tdata[35:28];

    logic [7:0]  rnd_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            rnd_reg <= in_rnd;
        end
    end

    // Opcode fields and display geometry.
    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [7:0]  geo_w;
    logic [6:0]  geo_h;
    logic [13:0] geo_total;

    assign op_x      = opc_reg[11:8];
    assign op_y      = opc_reg[7:4];
    assign op_n      = opc_reg[3:0];
    assign op_nn     = opc_reg[7:0];
    assign op_nnn    = opc_reg[11:0];
    assign geo_w     = hires_reg ? 8'd128 : 8'd64;
    assign geo_h     = hires_reg ? 7'd64 : 7'd32;
    assign geo_total = hires_reg ? 14'(DISP_PIXELS) : 14'(DISP_PIXELS / 4);

    // Fetch address and sprite geometry.
    logic [AW-1:0] fetch_a;
    logic          spr_big;
    logic [4:0]    spr_rows, spr_cols;
    logic [6:0]    spr_py;
    logic [7:0]    spr_px;
    logic [16:0]   spr_base;
    logic [12:0]   spr_idx;

    assign fetch_a  = mem_wrap({1'b0, pc_reg});
    assign spr_big  = (op_n == 4'd0) && hires_reg;
    assign spr_rows = spr_big ? 5'd16 : {1'b0, op_n};
    assign spr_cols = spr_big ? 5'd16 : 5'd8;
    assign spr_py   = yp_reg + {2'b0, r_reg};
    assign spr_px   = {1'b0, xp_reg} + {3'b0, c_reg};
    assign spr_base = {1'b0, i_reg} + (spr_big ? {11'b0, r_reg, 1'b0} : {12'b0, r_reg});
    assign spr_idx  = hires_reg ? {spr_py[5:0], spr_px[6:0]}
                                : {2'b0, spr_py[4:0], spr_px[5:0]};

    // Display walk for clears and scrolls.
    logic [12:0] wk_idx, wk_src, wk_lines;
    logic [7:0]  wk_col;
    logic        wk_zero;

    always_comb
    begin
        wk_idx   = wk_desc_reg ? 13'(wk_total_reg - 14'd1 - wk_cnt_reg) : wk_cnt_reg[12:0];
        wk_col   = hires_reg ? {1'b0, wk_idx[6:0]} : {2'b0, wk_idx[5:0]};
        wk_lines = hires_reg ? {2'b0, op_n, 7'b0} : {3'b0, op_n, 6'b0};
        wk_src   = wk_idx;
        wk_zero  = 1'b1;
        unique case (wk_kind_reg)
            WK_CLEAR:
            begin
                wk_zero = 1'b1;
            end
            WK_DOWN:
            begin
                wk_zero = (wk_idx < wk_lines);
                wk_src  = wk_idx - wk_lines;
            end
            WK_RIGHT:
            begin
                wk_zero = (wk_col < 8'd4);
                wk_src  = wk_idx - 13'd4;
            end
            WK_LEFT:
            begin
                wk_zero = (wk_col >= geo_w - 8'd4);
                wk_src  = wk_idx + 13'd4;
            end
            default:
            begin
                wk_zero = 1'b1;
            end
        endcase
    end

    // Lowest latched key for FX0A.
    logic       key_found;
    logic [3:0] key_idx;

    always_comb
    begin
        key_found = 1'b0;
        key_idx   = 4'd0;
        for (int j = 15; j >= 0; j--)
        begin
            if (keys_reg[j])
            begin
                key_found = 1'b1;
                key_idx   = 4'(j);
            end
        end
    end

    // Decimal digits of VX by reciprocal multiplication.
    logic [13:0] bcd_hp;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_tp;
    logic [3:0]  bcd_t;
    logic [3:0]  bcd_o;
    logic [7:0]  bcd_digit;

    always_comb
    begin
        bcd_hp  = 14'(vx_reg) * 14'd41;
        bcd_h   = bcd_hp[13:12];
        bcd_rem = 7'(vx_reg - 8'(bcd_h) * 8'd100);
        bcd_tp  = 15'(bcd_rem) * 15'd205;
        bcd_t   = bcd_tp[14:11];
        bcd_o   = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
        priority case (k_reg)
            4'd0:    bcd_digit = {6'b0, bcd_h};
            4'd1:    bcd_digit = {4'b0, bcd_t};
            default: bcd_digit = {4'b0, bcd_o};
        endcase
    end

    // 8XY5/6/7/E: operands seen after VF has taken the flag; 8XY4 adds the original VX and VY.
    logic [7:0] alu_vx, alu_vy, alu_res;

    always_comb
    begin
        alu_vx = (op_x == 4'hF) ? flag_reg : vx_reg;
        alu_vy = (op_y == 4'hF) ? flag_reg : vy_reg;
        priority case (op_n)
            4'h4:    alu_res = vx_reg + vy_reg;
            4'h5:    alu_res = alu_vx - alu_vy;
            4'h6:    alu_res = {1'b0, alu_vx[7:1]};
            4'h7:    alu_res = alu_vy - alu_vx;
            default: alu_res = {alu_vx[6:0], 1'b0};
        endcase
    end

    logic [8:0]    add_sum;
    logic [AW-1:0] idx_addr;

    assign add_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign idx_addr = mem_wrap({1'b0, i_reg} + {13'b0, k_reg});

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_out_next   = clr_out_reg;
        opc_next       = opc_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        flag_next      = flag_reg;
        hi_next        = hi_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        st_next        = st_reg;
        keys_next      = keys_reg;
        flags_next     = flags_reg;
        hires_next     = hires_reg;
        halt_next      = halt_reg;
        rd_next        = rd_reg;
        chg_next       = chg_reg;
        wait_next      = wait_reg;
        flt_next       = flt_reg;
        wk_kind_next   = wk_kind_reg;
        wk_desc_next   = wk_desc_reg;
        wk_cnt_next    = wk_cnt_reg;
        wk_total_next  = wk_total_reg;
        wk_phase_next  = wk_phase_reg;
        wk_dst_next    = wk_dst_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        bits_next      = bits_reg;
        coll_next      = coll_reg;
        xp_next        = xp_reg;
        yp_next        = yp_reg;
        k_next         = k_reg;
        blk_phase_next = blk_phase_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        dsp_we = 1'b0;
        dsp_wa = '0;
        dsp_wd = '0;
        dsp_ra = '0;
        v_we   = 1'b0;
        v_wa   = '0;
        v_wd   = '0;
        v_ra   = '0;
        stk_we = 1'b0;
        stk_wa = sp_reg[SW-1:0];
        stk_wd = pc_reg;
        stk_ra = SW'(sp_reg - LW'(1));

        unique case (state_reg)
            ST_CLEAR:
            begin
                if ({1'b0, clr_cnt_reg} < (CW+1)'(MEM_BYTES))
                begin
                    mem_we = 1'b1;
                    mem_wa = clr_cnt_reg[AW-1:0];
                    mem_wd = (clr_cnt_reg < CW'(FONT_BYTES)) ? FONT_ROM[clr_cnt_reg[6:0]] : 8'h00;
                end
                if ({1'b0, clr_cnt_reg} < (CW+1)'(DISP_PIXELS))
                begin
                    dsp_we = 1'b1;
                    dsp_wa = clr_cnt_reg[12:0];
                end
                if (clr_cnt_reg < CW'(16))
                begin
                    v_we = 1'b1;
                    v_wa = clr_cnt_reg[3:0];
                end
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CLR_LEN - 1))
                begin
                    state_next = clr_out_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rd_next    = 8'd0;
                    chg_next   = 1'b0;
                    wait_next  = 1'b0;
                    flt_next   = FLT_NONE;
                    state_next = ST_FINISH;
                    unique case (in_op)
                        OP_WRITE_MEM:
                        begin
                            mem_we = 1'b1;
                            mem_wa = mem_wrap({4'b0, in_addr});
                            mem_wd = in_data;
                        end
                        OP_STEP:
                        begin
                            if (!halt_reg)
                            begin
                                mem_ra     = fetch_a;
                                state_next = ST_FETCH1;
                            end
                        end
                        OP_TICK:
                        begin
                            dt_next = dt_reg - {7'b0, (dt_reg != 8'd0)};
                            st_next = st_reg - {7'b0, (st_reg != 8'd0)};
                        end
                        OP_KEY_PRESS:
                        begin
                            keys_next[in_key] = 1'b1;
                        end
                        OP_CLEAR_KEYS:
                        begin
                            keys_next = '0;
                        end
                        OP_READ_PIXEL:
                        begin
                            dsp_ra     = in_addr;
                            state_next = ST_RDPIX;
                        end
                        OP_READ_MEM:
                        begin
                            mem_ra     = mem_wrap({4'b0, in_addr});
                            state_next = ST_RDMEM;
                        end
                        OP_REINIT:
                        begin
                            i_next       = 16'd0;
                            pc_next      = 16'(PROGRAM_START);
                            sp_next      = '0;
                            dt_next      = 8'd0;
                            st_next      = 8'd0;
                            hires_next   = 1'b0;
                            halt_next    = 1'b0;
                            chg_next     = 1'b1;
                            clr_cnt_next = '0;
                            clr_out_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_RDPIX:
            begin
                rd_next    = {7'b0, dsp_rd};
                state_next = ST_FINISH;
            end

            ST_RDMEM:
            begin
                rd_next    = mem_rd;
                state_next = ST_FINISH;
            end

            ST_FETCH1:
            begin
                hi_next    = mem_rd;
                mem_ra     = mem_wrap({1'b0, pc_reg} + 17'd1);
                state_next = ST_FETCH2;
            end

            ST_FETCH2:
            begin
                opc_next   = {hi_reg, mem_rd};
                pc_next    = 16'({{(17-AW){1'b0}}, fetch_a} + 17'd2);
                v_ra       = hi_reg[3:0];
                state_next = ST_RDX;
            end

            ST_RDX:
            begin
                vx_next    = v_rd;
                v_ra       = op_y;
                state_next = ST_RDY;
            end

            ST_RDY:
            begin
                vy_next    = v_rd;
                v_ra       = 4'd0;
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_FINISH;
                unique case (opc_reg[15:12])
                    4'h0:
                    begin
                        wk_cnt_next   = '0;
                        wk_phase_next = 1'b0;
                        wk_total_next = geo_total;
                        if (opc_reg[15:4] == 12'h00C)
                        begin
                            wk_kind_next = WK_DOWN;
                            wk_desc_next = 1'b1;
                            chg_next     = 1'b1;
                            state_next   = ST_WALK;
                        end
                        else if (opc_reg == 16'h00E0)
                        begin
                            wk_kind_next = WK_CLEAR;
                            wk_desc_next = 1'b0;
                            chg_next     = 1'b1;
                            state_next   = ST_WALK;
                        end
                        else if (opc_reg == 16'h00EE)
                        begin
                            if (sp_reg == '0)
                            begin
                                halt_next = 1'b1;
                                flt_next  = FLT_UNDERFLOW;
                            end
                            else
                            begin
                                sp_next = sp_reg - LW'(1);
                                pc_next = stk_rd;
                            end
                        end
                        else if (opc_reg == 16'h00FB)
                        begin
                            wk_kind_next = WK_RIGHT;
                            wk_desc_next = 1'b1;
                            chg_next     = 1'b1;
                            state_next   = ST_WALK;
                        end
                        else if (opc_reg == 16'h00FC)
                        begin
                            wk_kind_next = WK_LEFT;
                            wk_desc_next = 1'b0;
                            chg_next     = 1'b1;
                            state_next   = ST_WALK;
                        end
                        else if (opc_reg == 16'h00FD)
                        begin
                            halt_next = 1'b1;
                            flt_next  = FLT_EXIT;
                        end
                        else if (opc_reg == 16'h00FE || opc_reg == 16'h00FF)
                        begin
                            // A mode switch clears the whole store, not just the old frame.
                            hires_next    = opc_reg[0];
                            wk_kind_next  = WK_CLEAR;
                            wk_desc_next  = 1'b0;
                            wk_total_next = 14'(DISP_PIXELS);
                            chg_next      = 1'b1;
                            state_next    = ST_WALK;
                        end
                        else
                        begin
                            flt_next = FLT_UNKNOWN;
                        end
                    end
                    4'h1:
                    begin
                        pc_next = {4'b0, op_nnn};
                    end
                    4'h2:
                    begin
                        if (sp_reg >= LW'(STACK_DEPTH))
                        begin
                            halt_next = 1'b1;
                            flt_next  = FLT_OVERFLOW;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + LW'(1);
                            pc_next = {4'b0, op_nnn};
                        end
                    end
                    4'h3:
                    begin
                        if (vx_reg == op_nn)
                        begin
                            pc_next = pc_reg + 16'd2;
                        end
                    end
                    4'h4:
                    begin
                        if (vx_reg != op_nn)
                        begin
                            pc_next = pc_reg + 16'd2;
                        end
                    end
                    4'h5:
                    begin
                        if (vx_reg == vy_reg)
                        begin
                            pc_next = pc_reg + 16'd2;
                        end
                    end
                    4'h6:
                    begin
                        v_we = 1'b1;
                        v_wa = op_x;
                        v_wd = op_nn;
                    end
                    4'h7:
                    begin
                        v_we = 1'b1;
                        v_wa = op_x;
                        v_wd = vx_reg + op_nn;
                    end
                    4'h8:
                    begin
                        v_wa = op_x;
                        unique case (op_n)
                            4'h0:
                            begin
                                v_we = 1'b1;
                                v_wd = vy_reg;
                            end
                            4'h1:
                            begin
                                v_we = 1'b1;
                                v_wd = vx_reg | vy_reg;
                            end
                            4'h2:
                            begin
                                v_we = 1'b1;
                                v_wd = vx_reg & vy_reg;
                            end
                            4'h3:
                            begin
                                v_we = 1'b1;
                                v_wd = vx_reg ^ vy_reg;
                            end
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                            begin
                                // VF takes the flag first; the result follows next cycle.
                                priority case (op_n)
                                    4'h4:    flag_next = {7'b0, add_sum[8]};
                                    4'h5:    flag_next = {7'b0, (vx_reg > vy_reg)};
                                    4'h6:    flag_next = {7'b0, vx_reg[0]};
                                    4'h7:    flag_next = {7'b0, (vy_reg > vx_reg)};
                                    default: flag_next = {7'b0, vx_reg[7]};
                                endcase
                                v_we       = 1'b1;
                                v_wa       = 4'hF;
                                v_wd       = flag_next;
                                state_next = ST_WB;
                            end
                            default:
                            begin
                                flt_next = FLT_UNKNOWN;
                            end
                        endcase
                    end
                    4'h9:
                    begin
                        if (vx_reg != vy_reg)
                        begin
                            pc_next = pc_reg + 16'd2;
                        end
                    end
                    4'hA:
                    begin
                        i_next = {4'b0, op_nnn};
                    end
                    4'hB:
                    begin
                        pc_next = {4'b0, op_nnn} + {8'b0, v_rd};
                    end
                    4'hC:
                    begin
                        v_we = 1'b1;
                        v_wa = op_x;
                        v_wd = rnd_reg & op_nn;
                    end
                    4'hD:
                    begin
                        xp_next    = vx_reg[6:0] & (hires_reg ? 7'h7F : 7'h3F);
                        yp_next    = {1'b0, vy_reg[5:0] & (hires_reg ? 6'h3F : 6'h1F)};
                        r_next     = '0;
                        coll_next  = 1'b0;
                        state_next = ST_SPR_ROW;
                    end
                    4'hE:
                    begin
                        if (op_nn == 8'h9E)
                        begin
                            if (keys_reg[vx_reg[3:0]])
                            begin
                                pc_next                = pc_reg + 16'd2;
                                keys_next[vx_reg[3:0]] = 1'b0;
                            end
                        end
                        else if (op_nn == 8'hA1)
                        begin
                            if (!keys_reg[vx_reg[3:0]])
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        else
                        begin
                            flt_next = FLT_UNKNOWN;
                        end
                    end
                    4'hF:
                    begin
                        k_next         = 4'd0;
                        blk_phase_next = 1'b0;
                        unique case (op_nn)
                            8'h07:
                            begin
                                v_we = 1'b1;
                                v_wa = op_x;
                                v_wd = dt_reg;
                            end
                            8'h0A:
                            begin
                                if (key_found)
                                begin
                                    v_we               = 1'b1;
                                    v_wa               = op_x;
                                    v_wd               = {4'b0, key_idx};
                                    keys_next[key_idx] = 1'b0;
                                end
                                else
                                begin
                                    pc_next   = pc_reg - 16'd2;
                                    wait_next = 1'b1;
                                end
                            end
                            8'h15:
                            begin
                                dt_next = vx_reg;
                            end
                            8'h18:
                            begin
                                st_next = vx_reg;
                            end
                            8'h1E:
                            begin
                                i_next = i_reg + {8'b0, vx_reg};
                            end
                            8'h29:
                            begin
                                i_next = 16'(vx_reg) * 16'd5;
                            end
                            8'h30:
                            begin
                                i_next = 16'(vx_reg) * 16'd10;
                            end
                            8'h33:
                            begin
                                state_next = ST_BCD;
                            end
                            8'h55, 8'h65:
                            begin
                                state_next = ST_BLK;
                            end
                            8'h75, 8'h85:
                            begin
                                if (!op_x[3])
                                begin
                                    state_next = ST_BLK;
                                end
                            end
                            default:
                            begin
                                flt_next = FLT_UNKNOWN;
                            end
                        endcase
                    end
                    default:
                    begin
                        flt_next = FLT_UNKNOWN;
                    end
                endcase
            end

            ST_WB:
            begin
                v_we       = 1'b1;
                v_wa       = op_x;
                v_wd       = alu_res;
                state_next = ST_FINISH;
            end

            ST_WALK:
            begin
                if (!wk_phase_reg && !wk_zero)
                begin
                    dsp_ra        = wk_src;
                    wk_dst_next   = wk_idx;
                    wk_phase_next = 1'b1;
                end
                else
                begin
                    dsp_we        = 1'b1;
                    dsp_wa        = wk_phase_reg ? wk_dst_reg : wk_idx;
                    dsp_wd        = wk_phase_reg ? dsp_rd : 1'b0;
                    wk_phase_next = 1'b0;
                    wk_cnt_next   = wk_cnt_reg + 14'd1;
                    if (wk_cnt_reg == wk_total_reg - 14'd1)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SPR_ROW:
            begin
                if (r_reg == spr_rows || spr_py >= geo_h)
                begin
                    state_next = ST_SPR_END;
                end
                else
                begin
                    mem_ra     = mem_wrap(spr_base);
                    state_next = ST_SPR_HI;
                end
            end

            ST_SPR_HI:
            begin
                hi_next    = mem_rd;
                mem_ra     = mem_wrap(spr_base + 17'd1);
                state_next = ST_SPR_LO;
            end

            ST_SPR_LO:
            begin
                bits_next  = {hi_reg, spr_big ? mem_rd : 8'h00};
                c_next     = '0;
                state_next = ST_SPR_COL;
            end

            ST_SPR_COL:
            begin
                if (c_reg == spr_cols || spr_px >= geo_w)
                begin
                    r_next     = r_reg + 5'd1;
                    state_next = ST_SPR_ROW;
                end
                else if (bits_reg[~c_reg[3:0]])
                begin
                    dsp_ra     = spr_idx;
                    state_next = ST_SPR_PIX;
                end
                else
                begin
                    c_next = c_reg + 5'd1;
                end
            end

            ST_SPR_PIX:
            begin
                dsp_we     = 1'b1;
                dsp_wa     = spr_idx;
                dsp_wd     = ~dsp_rd;
                coll_next  = coll_reg | dsp_rd[0];
                c_next     = c_reg + 5'd1;
                state_next = ST_SPR_COL;
            end

            ST_SPR_END:
            begin
                v_we       = 1'b1;
                v_wa       = 4'hF;
                v_wd       = {7'b0, coll_reg};
                chg_next   = 1'b1;
                state_next = ST_FINISH;
            end

            ST_BCD:
            begin
                mem_we = 1'b1;
                mem_wa = idx_addr;
                mem_wd = bcd_digit;
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd2)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_BLK:
            begin
                if (!blk_phase_reg)
                begin
                    v_ra           = k_reg;
                    mem_ra         = idx_addr;
                    blk_phase_next = 1'b1;
                end
                else
                begin
                    priority case (op_nn)
                        8'h55:
                        begin
                            mem_we = 1'b1;
                            mem_wa = idx_addr;
                            mem_wd = v_rd;
                        end
                        8'h65:
                        begin
                            v_we = 1'b1;
                            v_wa = k_reg;
                            v_wd = mem_rd;
                        end
                        8'h75:
                        begin
                            flags_next[k_reg[2:0]] = v_rd;
                        end
                        default:
                        begin
                            v_we = 1'b1;
                            v_wa = k_reg;
                            v_wd = flags_reg[k_reg[2:0]];
                        end
                    endcase
                    blk_phase_next = 1'b0;
                    k_next         = k_reg + 4'd1;
                    if (k_reg == op_x)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {flt_reg, wait_reg, halt_reg, hires_reg,
                                      (st_reg != 8'd0), chg_reg, pc_reg, rd_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_out_reg   <= 1'b0;
            pc_reg        <= 16'(PROGRAM_START);
            i_reg         <= 16'd0;
            sp_reg        <= '0;
            dt_reg        <= 8'd0;
            st_reg        <= 8'd0;
            keys_reg      <= '0;
            flags_reg     <= '0;
            hires_reg     <= 1'b0;
            halt_reg      <= 1'b0;
            wk_phase_reg  <= 1'b0;
            blk_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_out_reg   <= clr_out_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            dt_reg        <= dt_next;
            st_reg        <= st_next;
            keys_reg      <= keys_next;
            flags_reg     <= flags_next;
            hires_reg     <= hires_next;
            halt_reg      <= halt_next;
            wk_phase_reg  <= wk_phase_next;
            blk_phase_reg <= blk_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg      <= opc_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        flag_reg     <= flag_next;
        hi_reg       <= hi_next;
        rd_reg       <= rd_next;
        chg_reg      <= chg_next;
        wait_reg     <= wait_next;
        flt_reg      <= flt_next;
        wk_kind_reg  <= wk_kind_next;
        wk_desc_reg  <= wk_desc_next;
        wk_cnt_reg   <= wk_cnt_next;
        wk_total_reg <= wk_total_next;
        wk_dst_reg   <= wk_dst_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        bits_reg     <= bits_next;
        coll_reg     <= coll_next;
        xp_reg       <= xp_next;
        yp_reg       <= yp_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/chip8_checker.sv
// Port-level assertions for the CHIP-8 core and the bind that attaches them.
module chip8_checker
    import chip8_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[31:29] == FLT_OVERFLOW || m_tdata[31:29] == FLT_UNDERFLOW ||
                     m_tdata[31:29] == FLT_EXIT) |-> m_tdata[27])
        else $error("stack fault or exit without halt");

    a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[28] |-> m_tdata[31:29] == FLT_NONE && !m_tdata[24])
        else $error("key wait reported with fault or display change");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |->
            m_tdata[31:29] == FLT_NONE && !m_tdata[24] && !m_tdata[28])
        else $error("read data on a beat that was not a read");

endmodule

bind chip8_cpu_core_top chip8_checker u_chk (.*);
